### hw/rtl/sct_pkg.sv
package sct_pkg;

  localparam int KEY_W    = 10;
  localparam int HANDLE_W = 16;
  localparam int IDX_W    = 6;
  localparam int POS_W    = 7;

  // command codes
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [1:0]          command;
    logic [KEY_W-1:0]    channel_key;
    logic [HANDLE_W-1:0] entry_handle;
    logic [IDX_W-1:0]    read_index;
  } item_t;

  typedef struct packed {
    logic [POS_W-1:0]    position;
    logic [POS_W-1:0]    entry_count;
    logic [KEY_W-1:0]    key_out;
    logic [HANDLE_W-1:0] handle_out;
    logic [1:0]          status;
  } result_t;

  // broadcast control for the cell row
  typedef struct packed {
    logic                insert_en;
    logic [KEY_W-1:0]    new_key;
    logic [HANDLE_W-1:0] new_handle;
  } cell_ctl_t;

endpackage

### hw/rtl/sct_cell.sv
module sct_cell (
  input  logic                         clk,
  input  sct_pkg::cell_ctl_t           ctl,
  input  logic                         occupied,
  input  logic                         at_end,
  input  logic                         prev_gt,
  input  logic [sct_pkg::KEY_W-1:0]    prev_key,
  input  logic [sct_pkg::HANDLE_W-1:0] prev_handle,
  output logic [sct_pkg::KEY_W-1:0]    key,
  output logic [sct_pkg::HANDLE_W-1:0] handle,
  output logic                         gt,
  output logic                         land
);
  import sct_pkg::*;

  // held entry is larger than the new key
  assign gt   = occupied && (key > ctl.new_key);
  // first slot past the entries that are less or equal
  assign land = !prev_gt && (gt || at_end);

  // shift up from the neighbor or take the new entry
  always_ff @(posedge clk) begin
    if (ctl.insert_en) begin
      if (prev_gt) begin
        key    <= prev_key;
        handle <= prev_handle;
      end else if (land) begin
        key    <= ctl.new_key;
        handle <= ctl.new_handle;
      end
    end
  end

endmodule

### hw/rtl/sorted_channel_table_insert.sv
// Sorted table of (channel key, handle) entries kept in ascending key order in a
// row of CAPACITY compare-and-shift cells. Every item (insert, clear, read, no-op)
// yields one result: all cells compare the new key with their own entry in the same
// cycle and shift up or capture at once, so one item per cycle is accepted as long
// as the result register is drained. Equal keys keep arrival order. An insert into
// a full table is dropped with status full; a read at or past the count returns
// zero key and handle with status range. No clearing pass is needed after reset:
// only slots below the count are ever read.
module sorted_channel_table_insert #(
  parameter int CAPACITY = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  sct_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output sct_pkg::result_t result
);
  import sct_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;

  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic [XW-1:0]       count_x;
  logic [XW-1:0]       count_inc_x;
  logic [XW-1:0]       ridx_x;
  logic                item_fire;
  logic                full;
  cell_ctl_t           ctl;
  result_t             res_next;

  logic [KEY_W-1:0]    keys    [CAPACITY];
  logic [HANDLE_W-1:0] handles [CAPACITY];
  logic [CAPACITY-1:0] gt;
  logic [CAPACITY-1:0] land;
  logic [CAPACITY-1:0] rsel;

  logic [XW-1:0]       ins_pos;
  logic [KEY_W-1:0]    rd_key;
  logic [HANDLE_W-1:0] rd_handle;

  assign item_ready  = !result_valid || result_ready;
  assign item_fire   = item_valid && item_ready;
  assign count_x     = XW'(count);
  assign count_inc_x = count_x + XW'(1);
  assign ridx_x      = XW'(item.read_index);
  assign full        = (count_x >= XW'(CAPACITY));

  assign ctl.insert_en  = item_fire && (item.command == CMD_INSERT) && !full;
  assign ctl.new_key    = item.channel_key;
  assign ctl.new_handle = item.entry_handle;

  // cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                occ;
    logic                at_end;
    logic                pgt;
    logic [KEY_W-1:0]    pkey;
    logic [HANDLE_W-1:0] phandle;

    assign occ    = XW'(i) < count_x;
    assign at_end = XW'(i) == count_x;
    assign rsel[i] = XW'(i) == ridx_x;

    if (i == 0) begin : g_first
      assign pgt     = 1'b0;
      assign pkey    = '0;
      assign phandle = '0;
    end else begin : g_rest
      assign pgt     = gt[i-1];
      assign pkey    = keys[i-1];
      assign phandle = handles[i-1];
    end

    sct_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occupied    (occ),
      .at_end      (at_end),
      .prev_gt     (pgt),
      .prev_key    (pkey),
      .prev_handle (phandle),
      .key         (keys[i]),
      .handle      (handles[i]),
      .gt          (gt[i]),
      .land        (land[i])
    );
  end

  // encode landing slot and select read entry
  always_comb begin
    ins_pos   = '0;
    rd_key    = '0;
    rd_handle = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      ins_pos   = ins_pos | (land[i] ? XW'(i) : '0);
      rd_key    = rd_key | (rsel[i] ? keys[i] : '0);
      rd_handle = rd_handle | (rsel[i] ? handles[i] : '0);
    end
  end

  // result and next count
  always_comb begin
    count_next           = count;
    res_next.position    = '0;
    res_next.entry_count = count_x[POS_W-1:0];
    res_next.key_out     = '0;
    res_next.handle_out  = '0;
    res_next.status      = ST_OK;
    case (item.command)
      CMD_INSERT: begin
        if (full) begin
          res_next.position = count_x[POS_W-1:0];
          res_next.status   = ST_FULL;
        end else begin
          count_next           = count + CW'(1);
          res_next.position    = ins_pos[POS_W-1:0];
          res_next.entry_count = count_inc_x[POS_W-1:0];
        end
      end
      CMD_CLEAR: begin
        count_next           = '0;
        res_next.entry_count = '0;
      end
      CMD_READ: begin
        res_next.position = ridx_x[POS_W-1:0];
        if (ridx_x < count_x) begin
          res_next.key_out    = rd_key;
          res_next.handle_out = rd_handle;
        end else begin
          res_next.status = ST_RANGE;
        end
      end
      default: begin
      end
    endcase
  end

  // count and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (item_fire) begin
        count        <= count_next;
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire) begin
      result <= res_next;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count_x <= XW'(CAPACITY))
    else $error("entry count above capacity");

  a_one_landing: assert property (@(posedge clk) disable iff (rst)
    ctl.insert_en |-> $onehot(land))
    else $error("insert without exactly one landing slot");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    ctl.insert_en |=> count == $past(count) + CW'(1))
    else $error("insert did not grow the count by one");

  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    (item_fire && item.command == CMD_CLEAR) |=>
      (result_valid && result.entry_count == '0 && count == '0))
    else $error("clear did not empty the table");

  // larger held entries form one run at the top of the occupied slots
  a_gt_thermo: assert property (@(posedge clk) disable iff (rst)
    ctl.insert_en |-> $onehot0(gt & ~(gt << 1)))
    else $error("held entries out of key order");
`endif

endmodule

### tb/sorted_channel_table_checker.sv
`timescale 1ns / 1ps

module sorted_channel_table_checker #(
  parameter int CAPACITY = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic             item_ready,
  input  sct_pkg::item_t   item,
  input  logic             result_valid,
  input  logic             result_ready,
  input  sct_pkg::result_t result,
  output int               mismatches,
  output int               outstanding,
  output int               results_seen,
  output int               full_drops,
  output int               range_reads
);

  import sct_pkg::*;

  // shadow copy of the sorted table
  logic [KEY_W-1:0]    slot_keys    [CAPACITY];
  logic [HANDLE_W-1:0] slot_handles [CAPACITY];
  int                  fill;

  result_t expected_results [$];
  result_t want;

  initial begin
    mismatches   = 0;
    outstanding  = 0;
    results_seen = 0;
    full_drops   = 0;
    range_reads  = 0;
    fill         = 0;
  end

  // apply one item to the shadow table and return the result it should give
  function automatic result_t predict_table_op(input item_t it);
    result_t r;
    int      slot;
    r = '0;
    case (cmd_t'(it.command))
      CMD_INSERT: begin
        if (fill >= CAPACITY) begin
          r.position    = POS_W'(fill);
          r.entry_count = POS_W'(fill);
          r.status      = ST_FULL;
        end else begin
          // larger keys move up one slot, equal keys stay ahead of the new one
          slot = fill;
          while (slot > 0 && slot_keys[slot-1] > it.channel_key) begin
            slot_keys[slot]    = slot_keys[slot-1];
            slot_handles[slot] = slot_handles[slot-1];
            slot--;
          end
          slot_keys[slot]    = it.channel_key;
          slot_handles[slot] = it.entry_handle;
          fill++;
          r.position    = POS_W'(slot);
          r.entry_count = POS_W'(fill);
          r.status      = ST_OK;
        end
      end
      CMD_CLEAR: begin
        fill = 0;
      end
      CMD_READ: begin
        r.position    = POS_W'(it.read_index);
        r.entry_count = POS_W'(fill);
        if (int'(it.read_index) < fill) begin
          r.key_out    = slot_keys[it.read_index];
          r.handle_out = slot_handles[it.read_index];
          r.status     = ST_OK;
        end else begin
          r.status = ST_RANGE;
        end
      end
      default: begin
        r.entry_count = POS_W'(fill);
      end
    endcase
    return r;
  endfunction

  task automatic flag_field(input string name, input logic [31:0] exp_val,
                            input logic [31:0] got_val);
    $display("%0t: %s expected 0x%0h got 0x%0h", $time, name, exp_val, got_val);
    mismatches++;
  endtask

  // compare each result with the oldest prediction, then queue new predictions
  always @(posedge clk) begin
    if (rst) begin
      fill = 0;
      expected_results.delete();
      outstanding <= 0;
    end else begin
      if (result_valid && result_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t: result with no item pending, got %p", $time, result);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (result.position !== want.position)
            flag_field("position", 32'(want.position), 32'(result.position));
          if (result.entry_count !== want.entry_count)
            flag_field("entry_count", 32'(want.entry_count), 32'(result.entry_count));
          if (result.key_out !== want.key_out)
            flag_field("key_out", 32'(want.key_out), 32'(result.key_out));
          if (result.handle_out !== want.handle_out)
            flag_field("handle_out", 32'(want.handle_out), 32'(result.handle_out));
          if (result.status !== want.status)
            flag_field("status", 32'(want.status), 32'(result.status));
        end
      end
      if (item_valid && item_ready) begin
        want = predict_table_op(item);
        if (want.status == ST_FULL) full_drops++;
        if (want.status == ST_RANGE) range_reads++;
        expected_results.push_back(want);
      end
      outstanding <= expected_results.size();
    end
  end

endmodule

### tb/sorted_channel_table_insert_test.sv
`timescale 1ns / 1ps

module sorted_channel_table_insert_test;

  import sct_pkg::*;

  localparam int CAPACITY     = 64;
  localparam int RANDOM_ITEMS = 1500;
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 150;

  logic    clk          = 1'b0;
  logic    rst          = 1'b1;
  logic    item_valid   = 1'b0;
  item_t   item         = '0;
  logic    result_ready = 1'b0;
  logic    item_ready;
  logic    result_valid;
  result_t result;

  int mismatches;
  int results_owed;
  int results_seen;
  int full_drops;
  int range_reads;

  // sender bookkeeping
  int burst_left = 0;
  int items_sent = 0;
  int n_insert   = 0;
  int n_read     = 0;
  int n_clear    = 0;
  int n_nop      = 0;
  int fill_level = 0;

  // receiver bookkeeping
  int results_taken = 0;
  int hold_left     = 0;
  int holds_done    = 0;
  int ready_mode    = 0;
  int mode_left     = 0;

  int stall_cycles = 0;

  always #6 clk = ~clk;

  sorted_channel_table_insert #(.CAPACITY(CAPACITY)) dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  sorted_channel_table_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .mismatches   (mismatches),
    .outstanding  (results_owed),
    .results_seen (results_seen),
    .full_drops   (full_drops),
    .range_reads  (range_reads)
  );

  function automatic item_t pack_request(input cmd_t cmd, input int key, input int handle,
                                         input int idx);
    item_t r;
    r.command      = cmd;
    r.channel_key  = KEY_W'(key);
    r.entry_handle = HANDLE_W'(handle);
    r.read_index   = IDX_W'(idx);
    return r;
  endfunction

  // key spread: full range, a narrow band with many repeats, or the extremes
  function automatic int pick_key(input int mode, input int base);
    case (mode)
      0: return $urandom_range(0, 1023);
      1: return base + $urandom_range(0, 3);
      default: begin
        case ($urandom_range(0, 3))
          0: return 0;
          1: return 1;
          2: return 1022;
          default: return 1023;
        endcase
      end
    endcase
  endfunction

  // offer one item, opening a new burst after a random gap when the last one ran out
  task automatic offer_item(input item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? 80 : $urandom_range(1, 24);
    end
    item       <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    burst_left--;
    items_sent++;
    case (cmd_t'(it.command))
      CMD_INSERT: begin
        n_insert++;
        if (fill_level < CAPACITY) fill_level++;
      end
      CMD_CLEAR: begin
        n_clear++;
        fill_level = 0;
      end
      CMD_READ: n_read++;
      default:  n_nop++;
    endcase
  endtask

  task automatic offer_read();
    int idx;
    if (fill_level > 0 && $urandom_range(0, 3) != 0)
      idx = $urandom_range(0, fill_level - 1);
    else
      idx = $urandom_range(0, 63);
    offer_item(pack_request(CMD_READ, $urandom_range(0, 1023), $urandom_range(0, 65535),
                            idx));
  endtask

  // stop sending and wait until every predicted result has come back
  task automatic drain_results();
    item_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  // stimulus
  initial begin
    int target;
    int inserted;
    int key_mode;
    int key_base;
    int roll;
    bit paused_midway;
    paused_midway = 1'b0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty table, extremes, equal keys, read past count, clear
    offer_item(pack_request(CMD_READ, 0, 0, 0));
    offer_item(pack_request(CMD_READ, 1023, 65535, 63));
    offer_item(pack_request(CMD_NOP, 1023, 65535, 63));
    offer_item(pack_request(CMD_INSERT, 512, 1, 0));
    offer_item(pack_request(CMD_INSERT, 512, 2, 63));
    offer_item(pack_request(CMD_INSERT, 0, 0, 0));
    offer_item(pack_request(CMD_INSERT, 1023, 65535, 0));
    offer_item(pack_request(CMD_INSERT, 512, 3, 0));
    offer_item(pack_request(CMD_INSERT, 511, 4, 0));
    offer_item(pack_request(CMD_INSERT, 513, 5, 0));
    for (int i = 0; i < 8; i++) offer_item(pack_request(CMD_READ, 0, 0, i));
    offer_item(pack_request(CMD_READ, 0, 0, 63));
    offer_item(pack_request(CMD_NOP, 0, 0, 0));
    offer_item(pack_request(CMD_CLEAR, 1023, 65535, 63));
    offer_item(pack_request(CMD_READ, 0, 0, 0));
    offer_item(pack_request(CMD_INSERT, 1023, 65535, 0));
    offer_item(pack_request(CMD_READ, 0, 0, 0));
    offer_item(pack_request(CMD_CLEAR, 0, 0, 0));
    drain_results();

    // random fill episodes, some running past capacity
    while (items_sent < RANDOM_ITEMS) begin
      target   = ($urandom_range(0, 5) == 0) ? $urandom_range(66, 80)
                                             : $urandom_range(1, 40);
      key_mode = $urandom_range(0, 2);
      key_base = $urandom_range(0, 1020);
      inserted = 0;
      while (inserted < target && items_sent < RANDOM_ITEMS) begin
        roll = $urandom_range(0, 99);
        if (roll < 65) begin
          offer_item(pack_request(CMD_INSERT, pick_key(key_mode, key_base),
                                  $urandom_range(0, 65535), $urandom_range(0, 63)));
          inserted++;
        end else if (roll < 92) begin
          offer_read();
        end else if (roll < 97) begin
          offer_item(pack_request(CMD_NOP, $urandom_range(0, 1023),
                                  $urandom_range(0, 65535), $urandom_range(0, 63)));
        end else begin
          // clear in the middle of a fill
          offer_item(pack_request(CMD_CLEAR, $urandom_range(0, 1023),
                                  $urandom_range(0, 65535), $urandom_range(0, 63)));
        end
      end
      repeat ($urandom_range(1, 6)) offer_read();
      offer_item(pack_request(CMD_CLEAR, $urandom_range(0, 1023),
                              $urandom_range(0, 65535), $urandom_range(0, 63)));
      if (!paused_midway && items_sent >= RANDOM_ITEMS / 2) begin
        drain_results();
        paused_midway = 1'b1;
      end
    end

    drain_results();
    repeat (20) @(posedge clk);

    $display("covered %0d items: %0d inserts (%0d dropped on a full table), %0d reads",
             items_sent, n_insert, full_drops, n_read);
    $display("  (%0d past the count), %0d clears, %0d no-ops; %0d results checked",
             range_reads, n_clear, n_nop, results_seen);
    if (mismatches == 0 && results_owed == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // receiver: random stall modes plus two long hold-offs
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) results_taken++;
      if (hold_left == 0 && holds_done < 2 &&
          results_taken >= (holds_done == 0 ? 300 : 1000)) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          ready_mode = $urandom_range(0, 2);
          mode_left  = $urandom_range(10, 60);
        end
        mode_left--;
        case (ready_mode)
          0:       result_ready <= 1'b1;
          1:       result_ready <= 1'($urandom_range(0, 1));
          default: result_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, stall_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule

### sorted_channel_table_insert.f
hw/rtl/sct_pkg.sv
hw/rtl/sct_cell.sv
hw/rtl/sorted_channel_table_insert.sv
tb/sorted_channel_table_checker.sv
tb/sorted_channel_table_insert_test.sv
